FILE: hw/rtl/rhhs_pkg.sv
package rhhs_pkg;

  // fixed field widths
  localparam int KEY_W      = 64;
  localparam int OP_W       = 3;
  localparam int POS_W      = 10;
  localparam int STATUS_W   = 2;
  localparam int LIVE_W     = 11;
  localparam int CFG_W      = 4;
  localparam int HASH_W     = 32;
  localparam int TABLE_LOG2_DEF = 10;

  localparam logic [CFG_W-1:0] LEN_LOG2_RST = 4'd10;
  localparam int               LEN_LOG2_MIN = 2;

  // murmur3 finalizer constants
  localparam logic [63:0] MIX1      = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX2      = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;
  localparam int          KEY_SHIFT = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_DEL   = 3'd1,
    OP_TEST  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_GET   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_TRUE  = 2'd0,
    ST_FALSE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    hash_go;
    logic    hash_q;
    logic    home_save;
    logic    probe_init;
    logic    rd;
    logic    adv;
    logic    swap;
    logic    wr_carry;
    logic    used_inc;
    logic    live_inc;
    logic    wr_tomb;
    logic    scan_init;
    logic    left_dec;
    logic    clr_start;
    logic    clr_step;
    logic    resp;
    status_t resp_status;
    logic    resp_elem;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            key_ok;
    logic            hash_done;
    logic            rd_zero;
    logic            rd_match;
    logic            rd_tomb;
    logic            rd_live;
    logic            closer;
    logic            dist_end;
    logic            full;
    logic            pos_in_range;
    logic            left_zero;
    logic            sweep_end;
    logic            out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/rhhs_if.sv
interface rhhs_in_if;
  import rhhs_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   key;
  logic [POS_W-1:0]   position;
  modport source (output valid, operation, key, position, input ready);
  modport sink   (input valid, operation, key, position, output ready);
endinterface

interface rhhs_out_if;
  import rhhs_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    element;
  logic [LIVE_W-1:0]   live_count;
  modport source (output valid, status, element, live_count, input ready);
  modport sink   (input valid, status, element, live_count, output ready);
endinterface

FILE: hw/rtl/robin_hood_hash_set_core.sv
// Operation: each hash runs two multiply rounds; test/delete hash the key, then probe, hashing
//   each resident passed to find its distance; add repeats the probe for insertion; get scans
//   the slots in order; clear sweeps all 2^TABLE_LOG2 slots.
// Throughput: one item at a time, set by the shared 32x32 hash multiplier and the
//   one-read, one-write store; a waiting result does not block accepting the next item.
// Reset: synchronous active-low; a clearing pass over all 2^TABLE_LOG2 slots follows reset
//   and every length write, during which no item is accepted.
module robin_hood_hash_set_core import rhhs_pkg::*; #(
  parameter int TABLE_LOG2 = TABLE_LOG2_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rhhs_in_if.sink           in_bus,
  rhhs_out_if.source        out_bus,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [CFG_W-1:0] len_log2_r;
  logic             cfg_wr;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  // length register on the apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? {{(32-CFG_W){1'b0}}, len_log2_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_log2_r <= LEN_LOG2_RST;
    end else if (cfg_wr) begin
      len_log2_r <= pwdata[CFG_W-1:0];
    end
  end

  rhhs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .cfg_wr   (cfg_wr),
    .sts      (sts),
    .cmd      (cmd)
  );

  rhhs_dp #(.TABLE_LOG2(TABLE_LOG2)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .len_log2       (len_log2_r),
    .in_op          (in_bus.operation),
    .in_key         (in_bus.key),
    .in_position    (in_bus.position),
    .out_valid      (out_bus.valid),
    .out_ready      (out_bus.ready),
    .out_status     (out_bus.status),
    .out_element    (out_bus.element),
    .out_live_count (out_bus.live_count)
  );

endmodule

FILE: hw/rtl/rhhs_ram.sv
module rhhs_ram #(
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [(1 << ADDR_W)];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/rhhs_hash.sv
module rhhs_hash import rhhs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  din,
  output logic              busy,
  output logic              done,
  output logic [HASH_W-1:0] res
);

  typedef enum logic [2:0] {HS_M0, HS_M1, HS_M2, HS_ACC, HS_FIN} hstep_t;

  hstep_t      step_r;
  logic        rnd_r, busy_r, done_r;
  logic [63:0] a_r, acc_r, prod_r;
  logic [HASH_W-1:0] res_r;
  logic [63:0] cst, x, seed, fin;
  logic [31:0] mul_a, mul_b;

  // operand select for the shared 32x32 multiplier
  always_comb begin
    cst  = rnd_r ? MIX2 : MIX1;
    x    = din >> KEY_SHIFT;
    seed = x ^ (x >> MIX_SHIFT);
    fin  = acc_r ^ (acc_r >> MIX_SHIFT);
    unique case (step_r)
      HS_M1: begin
        mul_a = a_r[63:32];
        mul_b = cst[31:0];
      end
      HS_M2: begin
        mul_a = a_r[31:0];
        mul_b = cst[63:32];
      end
      default: begin
        mul_a = a_r[31:0];
        mul_b = cst[31:0];
      end
    endcase
  end

  // two rounds of multiply and xor-shift, low 64 bits of each product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= HS_M0;
      rnd_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= seed;
        step_r <= HS_M0;
        rnd_r  <= 1'b0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        unique case (step_r)
          HS_M0: begin
            prod_r <= mul_a * mul_b;
            step_r <= HS_M1;
          end
          HS_M1: begin
            acc_r  <= prod_r;
            prod_r <= mul_a * mul_b;
            step_r <= HS_M2;
          end
          HS_M2: begin
            acc_r  <= acc_r + {prod_r[31:0], 32'd0};
            prod_r <= mul_a * mul_b;
            step_r <= HS_ACC;
          end
          HS_ACC: begin
            acc_r  <= acc_r + {prod_r[31:0], 32'd0};
            step_r <= HS_FIN;
          end
          HS_FIN: begin
            a_r    <= fin;
            step_r <= HS_M0;
            if (rnd_r) begin
              res_r  <= fin[HASH_W-1:0];
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else begin
              rnd_r <= 1'b1;
            end
          end
          default: step_r <= HS_M0;
        endcase
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: hw/rtl/rhhs_ctrl.sv
module rhhs_ctrl import rhhs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    cfg_wr,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_HKEY, S_PINIT, S_FRD, S_FCHK, S_FHASH,
    S_ABSENT, S_IRD, S_ICHK, S_IHASH, S_GRD, S_GCHK, S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    elem_r, elem_nxt;
  logic    clr_resp_r, clr_resp_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and per-cycle datapath commands
  always_comb begin
    cmd          = '0;
    cmd.resp_status = st_r;
    cmd.resp_elem   = elem_r;
    state_nxt    = state_r;
    st_nxt       = st_r;
    elem_nxt     = elem_r;
    clr_resp_nxt = clr_resp_r;
    if (cfg_wr) begin
      cmd.clr_start = 1'b1;
      clr_resp_nxt  = 1'b0;
      state_nxt     = S_CLR;
    end else begin
      unique case (state_r)
        S_CLR: begin
          cmd.clr_step = 1'b1;
          if (sts.sweep_end) begin
            st_nxt    = ST_TRUE;
            state_nxt = clr_resp_r ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd.load  = 1'b1;
            elem_nxt  = 1'b0;
            state_nxt = S_DISP;
          end
        end
        S_DISP: begin
          unique case (sts.op)
            OP_ADD, OP_DEL, OP_TEST: begin
              if (sts.key_ok) begin
                cmd.hash_go = 1'b1;
                state_nxt   = S_HKEY;
              end else begin
                st_nxt    = ST_FALSE;
                state_nxt = S_RESP;
              end
            end
            OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              clr_resp_nxt  = 1'b1;
              state_nxt     = S_CLR;
            end
            OP_GET: begin
              if (sts.pos_in_range) begin
                cmd.scan_init = 1'b1;
                state_nxt     = S_GRD;
              end else begin
                st_nxt    = ST_FALSE;
                state_nxt = S_RESP;
              end
            end
            default: begin
              st_nxt    = ST_FALSE;
              state_nxt = S_RESP;
            end
          endcase
        end
        S_HKEY: begin
          if (sts.hash_done) begin
            cmd.home_save = 1'b1;
            state_nxt     = S_PINIT;
          end
        end
        S_PINIT: begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_FRD;
        end
        // lookup probe
        S_FRD: begin
          if (sts.dist_end) begin
            state_nxt = S_ABSENT;
          end else begin
            cmd.rd    = 1'b1;
            state_nxt = S_FCHK;
          end
        end
        S_FCHK: begin
          priority if (sts.rd_match) begin
            state_nxt = S_RESP;
            if (sts.op == OP_ADD) begin
              st_nxt = ST_FALSE;
            end else if (sts.op == OP_DEL) begin
              cmd.wr_tomb = 1'b1;
              st_nxt      = ST_TRUE;
            end else begin
              st_nxt = ST_TRUE;
            end
          end else if (sts.rd_zero) begin
            state_nxt = S_ABSENT;
          end else begin
            cmd.hash_go = 1'b1;
            cmd.hash_q  = 1'b1;
            state_nxt   = S_FHASH;
          end
        end
        S_FHASH: begin
          if (sts.hash_done) begin
            if (sts.closer) begin
              state_nxt = S_ABSENT;
            end else begin
              cmd.adv   = 1'b1;
              state_nxt = S_FRD;
            end
          end
        end
        S_ABSENT: begin
          state_nxt = S_RESP;
          if (sts.op == OP_ADD) begin
            if (sts.full) begin
              st_nxt = ST_FULL;
            end else begin
              cmd.probe_init = 1'b1;
              state_nxt      = S_IRD;
            end
          end else begin
            st_nxt = ST_FALSE;
          end
        end
        // insertion probe with displacement
        S_IRD: begin
          cmd.rd    = 1'b1;
          state_nxt = S_ICHK;
        end
        S_ICHK: begin
          if (sts.rd_zero) begin
            cmd.wr_carry = 1'b1;
            cmd.used_inc = 1'b1;
            cmd.live_inc = 1'b1;
            st_nxt       = ST_TRUE;
            state_nxt    = S_RESP;
          end else begin
            cmd.hash_go = 1'b1;
            cmd.hash_q  = 1'b1;
            state_nxt   = S_IHASH;
          end
        end
        S_IHASH: begin
          if (sts.hash_done) begin
            state_nxt = S_IRD;
            priority if (sts.closer && sts.rd_tomb) begin
              cmd.wr_carry = 1'b1;
              cmd.live_inc = 1'b1;
              st_nxt       = ST_TRUE;
              state_nxt    = S_RESP;
            end else if (sts.closer) begin
              cmd.swap = 1'b1;
            end else begin
              cmd.adv = 1'b1;
            end
          end
        end
        // slot-order scan for get
        S_GRD: begin
          cmd.rd    = 1'b1;
          state_nxt = S_GCHK;
        end
        S_GCHK: begin
          if (sts.rd_live && sts.left_zero) begin
            st_nxt    = ST_TRUE;
            elem_nxt  = 1'b1;
            state_nxt = S_RESP;
          end else begin
            cmd.left_dec = sts.rd_live;
            cmd.adv      = 1'b1;
            state_nxt    = S_GRD;
          end
        end
        S_RESP: begin
          if (sts.out_free) begin
            cmd.resp  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      st_r       <= ST_TRUE;
      elem_r     <= 1'b0;
      clr_resp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      st_r       <= st_nxt;
      elem_r     <= elem_nxt;
      clr_resp_r <= clr_resp_nxt;
    end
  end

endmodule

FILE: hw/rtl/rhhs_dp.sv
module rhhs_dp import rhhs_pkg::*; #(
  parameter int TABLE_LOG2 = TABLE_LOG2_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [CFG_W-1:0]    len_log2,
  input  logic [OP_W-1:0]     in_op,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [POS_W-1:0]    in_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [KEY_W-1:0]    out_element,
  output logic [LIVE_W-1:0]   out_live_count
);

  localparam int PW = TABLE_LOG2;
  localparam int CW = TABLE_LOG2 + 1;

  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r, carry_r;
  logic [POS_W-1:0] position_r, left_r;
  logic [PW-1:0]    home_r, pos_r, clr_idx_r;
  logic [CW-1:0]    dist_r, live_r, used_r;
  logic             out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [KEY_W-1:0]    out_element_r;
  logic [LIVE_W-1:0]   out_live_r;

  logic [4:0]       lg;
  logic [CW-1:0]    len_c;
  logic [PW-1:0]    mask_c, d_c, pos_inc;
  logic             hash_busy, hash_done;
  logic [HASH_W-1:0] hash_res;
  logic [KEY_W-1:0] q, wdata;
  logic             we;
  logic [PW-1:0]    waddr;
  logic             out_free;

  // clamp the configured length
  always_comb begin
    if (len_log2 < CFG_W'(LEN_LOG2_MIN)) begin
      lg = 5'(LEN_LOG2_MIN);
    end else if (int'(len_log2) > TABLE_LOG2) begin
      lg = 5'(TABLE_LOG2);
    end else begin
      lg = {1'b0, len_log2};
    end
    len_c   = CW'(1) << lg;
    mask_c  = PW'(len_c - CW'(1));
    d_c     = (pos_r - hash_res[PW-1:0]) & mask_c;
    pos_inc = (pos_r + PW'(1)) & mask_c;
  end

  rhhs_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.hash_go),
    .din   (cmd.hash_q ? q : key_r),
    .busy  (hash_busy),
    .done  (hash_done),
    .res   (hash_res)
  );

  // store write select: sweep, then insert, then tombstone
  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = carry_r;
    priority if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_idx_r;
      wdata = '0;
    end else if (cmd.swap || cmd.wr_carry) begin
      we = 1'b1;
    end else if (cmd.wr_tomb) begin
      we    = 1'b1;
      wdata = key_r | KEY_W'(1);
    end
  end

  rhhs_ram #(.WIDTH(KEY_W), .ADDR_W(PW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (pos_r),
    .rdata (q)
  );

  assign out_free = !out_valid_r || out_ready;

  // status toward the controller
  always_comb begin
    sts.op           = op_r;
    sts.key_ok       = (key_r != '0) && !key_r[0];
    sts.hash_done    = hash_done;
    sts.rd_zero      = (q == '0);
    sts.rd_match     = (q == key_r);
    sts.rd_tomb      = q[0];
    sts.rd_live      = (q != '0) && !q[0];
    sts.closer       = CW'(d_c) < dist_r;
    sts.dist_end     = (dist_r == len_c);
    sts.full         = ((CW+1)'(used_r) + (CW+1)'(1)) >= (CW+1)'(len_c);
    sts.pos_in_range = (CW+POS_W)'(position_r) < (CW+POS_W)'(live_r);
    sts.left_zero    = (left_r == '0);
    sts.sweep_end    = (clr_idx_r == '1);
    sts.out_free     = out_free;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_op;
      key_r      <= in_key;
      position_r <= in_position;
    end
    if (cmd.home_save) begin
      home_r <= hash_res[PW-1:0] & mask_c;
    end
    if (cmd.probe_init) begin
      pos_r   <= home_r;
      dist_r  <= '0;
      carry_r <= key_r;
    end else if (cmd.scan_init) begin
      pos_r  <= '0;
      left_r <= position_r;
    end else if (cmd.swap) begin
      carry_r <= q;
      dist_r  <= CW'(d_c) + CW'(1);
      pos_r   <= pos_inc;
    end else if (cmd.adv) begin
      dist_r <= dist_r + CW'(1);
      pos_r  <= pos_inc;
      if (cmd.left_dec) begin
        left_r <= left_r - POS_W'(1);
      end
    end
    if (cmd.resp) begin
      out_status_r  <= cmd.resp_status;
      out_element_r <= cmd.resp_elem ? q : '0;
      out_live_r    <= LIVE_W'(live_r);
    end
  end

  // counts, sweep index and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      used_r      <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        live_r    <= '0;
        used_r    <= '0;
        clr_idx_r <= '0;
      end else begin
        if (cmd.clr_step) begin
          clr_idx_r <= clr_idx_r + PW'(1);
        end
        if (cmd.live_inc) begin
          live_r <= live_r + CW'(1);
        end else if (cmd.wr_tomb) begin
          live_r <= live_r - CW'(1);
        end
        if (cmd.used_inc) begin
          used_r <= used_r + CW'(1);
        end
      end
      if (cmd.resp) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_element    = out_element_r;
  assign out_live_count = out_live_r;

  // live keys never exceed occupied slots
  a_live_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= used_r) else $error("live count above used slots");

  // a displaced resident is always a live key
  a_swap_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap |-> (q != '0) && !q[0]) else $error("swap of empty or tombstone");

  // a result is only loaded when the output register can take it
  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp |-> out_free) else $error("result overwritten");

  // the hash unit is never restarted mid-computation
  a_hash_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hash_go |-> !hash_busy) else $error("hash restarted while busy");

endmodule

FILE: tb/tb_robin_hood_hash_set_core.sv
module tb_robin_hood_hash_set_core;
  import rhhs_pkg::*;

  localparam int DEPTH = 1 << TABLE_LOG2_DEF;
  localparam logic [1:0] REG_LEN_LOG2 = 2'd0;
  localparam int LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rhhs_in_if in_bus ();
  rhhs_out_if out_bus ();

  robin_hood_hash_set_core dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result beat as predicted
  typedef struct {
    status_t           status;
    logic [KEY_W-1:0]  element;
    logic [LIVE_W-1:0] live_count;
  } answer_t;

  // shadow of the set
  logic [KEY_W-1:0] slots [DEPTH];
  int unsigned live_keys;
  int unsigned used_cnt;
  logic [CFG_W-1:0] len_log2;

  answer_t answers [$];
  logic [KEY_W-1:0] known_keys [$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int got = 0;
  int n_full = 0;
  int n_get = 0;
  bit stall_on = 1'b0;

  task automatic report(input string what, input logic [63:0] seen, input logic [63:0] want);
    errors++;
    $display("mismatch beat %0d %s: got %0h expected %0h", got, what, seen, want);
  endtask

  function automatic int unsigned slot_count();
    int unsigned lg;
    lg = len_log2;
    if (lg < LEN_LOG2_MIN) lg = LEN_LOG2_MIN;
    if (lg > TABLE_LOG2_DEF) lg = TABLE_LOG2_DEF;
    return 1 << lg;
  endfunction

  function automatic int unsigned home_slot(logic [KEY_W-1:0] k, int unsigned len);
    logic [63:0] h;
    h = k >> KEY_SHIFT;
    h ^= h >> MIX_SHIFT;
    h *= MIX1;
    h ^= h >> MIX_SHIFT;
    h *= MIX2;
    h ^= h >> MIX_SHIFT;
    return h[31:0] & (len - 1);
  endfunction

  function automatic int unsigned probe_len(logic [KEY_W-1:0] r, int unsigned s,
                                            int unsigned len);
    return (s + len - home_slot(r, len)) & (len - 1);
  endfunction

  function automatic int lookup(logic [KEY_W-1:0] k, int unsigned len);
    int unsigned p;
    p = home_slot(k, len);
    for (int unsigned d = 0; d < len; d++) begin
      if (slots[p] == k) return p;
      if (slots[p] == '0) return -1;
      if (d > probe_len(slots[p], p, len)) return -1;
      p = (p + 1) & (len - 1);
    end
    return -1;
  endfunction

  function automatic void place(logic [KEY_W-1:0] k, int unsigned len);
    int unsigned p;
    int unsigned d;
    logic [KEY_W-1:0] r;
    p = home_slot(k, len);
    d = 0;
    while (d < len) begin
      r = slots[p];
      if (r == '0) begin
        slots[p] = k;
        used_cnt++;
        return;
      end
      if (probe_len(r, p, len) < d) begin
        slots[p] = k;
        if (r[0]) return;
        k = r;
        d = probe_len(r, p, len);
      end
      p = (p + 1) & (len - 1);
      d++;
    end
  endfunction

  function automatic void wipe();
    foreach (slots[i]) slots[i] = '0;
    live_keys = 0;
    used_cnt = 0;
  endfunction

  function automatic answer_t apply_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                       logic [POS_W-1:0] pos);
    answer_t a;
    int unsigned len;
    int s;
    int unsigned left;
    bit ok;
    len = slot_count();
    a.status = ST_FALSE;
    a.element = '0;
    ok = (k != '0) && !k[0];
    if (op == OP_ADD && ok) begin
      if (lookup(k, len) >= 0) a.status = ST_FALSE;
      else if (used_cnt + 1 >= len) a.status = ST_FULL;
      else begin
        place(k, len);
        live_keys++;
        a.status = ST_TRUE;
      end
    end else if (op == OP_DEL && ok) begin
      s = lookup(k, len);
      if (s >= 0) begin
        slots[s][0] = 1'b1;
        live_keys--;
        a.status = ST_TRUE;
      end
    end else if (op == OP_TEST && ok) begin
      a.status = lookup(k, len) >= 0 ? ST_TRUE : ST_FALSE;
    end else if (op == OP_CLEAR) begin
      wipe();
      a.status = ST_TRUE;
    end else if (op == OP_GET && pos < live_keys) begin
      left = pos;
      for (int unsigned i = 0; i < len; i++) begin
        if (slots[i] == '0 || slots[i][0]) continue;
        if (left == 0) begin
          a.element = slots[i];
          a.status = ST_TRUE;
          break;
        end
        left--;
      end
    end
    a.live_count = live_keys[LIVE_W-1:0];
    return a;
  endfunction

  // input beat driven at the falling edge, held until accepted
  task automatic send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                      input logic [POS_W-1:0] pos, input bit pinned, input answer_t want);
    answer_t a;
    in_bus.valid <= 1'b1;
    in_bus.operation <= op;
    in_bus.key <= k;
    in_bus.position <= pos;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    a = apply_op(op, k, pos);
    if (pinned && (a.status != want.status || a.element != want.element ||
                   a.live_count != want.live_count))
      report("table row vs predictor", 64'({a.status, a.live_count}),
             64'({want.status, want.live_count}));
    if (op == OP_ADD && a.status == ST_FULL) n_full++;
    if (op == OP_GET) n_get++;
    answers.push_back(a);
    sent++;
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    go_idle();
    while (answers.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_len(input logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_LEN_LOG2; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    len_log2 = v[CFG_W-1:0];
    wipe();
    known_keys.delete();
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = {$urandom(), $urandom()};
      1: k = 64'($urandom_range(1, 300)) << 1;
      2: k = {$urandom(), $urandom()} << $urandom_range(0, 63);
      default: k = {~$urandom(), $urandom()};
    endcase
    k[0] = 1'b0;
    if (k == '0) k = 64'h2;
    return k;
  endfunction

  // result side: sample at the rising edge
  always @(posedge clk) begin
    answer_t w;
    cycles++;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (answers.size() == 0) begin
        report("beat with nothing pending", 64'(out_bus.status), 64'd0);
      end else begin
        w = answers.pop_front();
        if (out_bus.status != w.status)
          report("status", 64'(out_bus.status), 64'(w.status));
        if (out_bus.element != w.element) report("element", out_bus.element, w.element);
        if (out_bus.live_count != w.live_count)
          report("live_count", 64'(out_bus.live_count), 64'(w.live_count));
      end
      got++;
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (!stall_on) out_bus.ready <= 1'b1;
    else out_bus.ready <= ((cycles % 11) < 7) && ($urandom_range(0, 3) != 0);
  end

  typedef struct {
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] k;
    logic [POS_W-1:0] pos;
    bit pinned;
    status_t st;
    logic [KEY_W-1:0] el;
    logic [LIVE_W-1:0] lc;
  } row_t;

  row_t rows [] = '{
    '{OP_GET,   64'h0,                  10'd0,    1, ST_FALSE, 64'h0, 11'd0},
    '{OP_TEST,  64'h8,                  10'd0,    1, ST_FALSE, 64'h0, 11'd0},
    '{OP_ADD,   64'h0,                  10'd0,    1, ST_FALSE, 64'h0, 11'd0},
    '{OP_ADD,   64'h1,                  10'd0,    1, ST_FALSE, 64'h0, 11'd0},
    '{OP_ADD,   64'hffff_ffff_ffff_fffe, 10'd0,   1, ST_TRUE,  64'h0, 11'd1},
    '{OP_ADD,   64'hffff_ffff_ffff_fffe, 10'd0,   1, ST_FALSE, 64'h0, 11'd1},
    '{OP_ADD,   64'h2,                  10'd0,    1, ST_TRUE,  64'h0, 11'd2},
    '{OP_ADD,   64'h8000_0000_0000_0000, 10'd0,   1, ST_TRUE,  64'h0, 11'd3},
    '{OP_TEST,  64'h2,                  10'd0,    1, ST_TRUE,  64'h0, 11'd3},
    '{OP_GET,   64'h0,                  10'd0,    0, ST_TRUE,  64'h0, 11'd0},
    '{OP_GET,   64'h0,                  10'd2,    0, ST_TRUE,  64'h0, 11'd0},
    '{OP_GET,   64'h0,                  10'd3,    1, ST_FALSE, 64'h0, 11'd3},
    '{OP_GET,   64'h0,                  10'd1023, 1, ST_FALSE, 64'h0, 11'd3},
    '{OP_DEL,   64'h2,                  10'd0,    1, ST_TRUE,  64'h0, 11'd2},
    '{OP_DEL,   64'h2,                  10'd0,    1, ST_FALSE, 64'h0, 11'd2},
    '{OP_DEL,   64'h3,                  10'd0,    1, ST_FALSE, 64'h0, 11'd2},
    '{OP_TEST,  64'h0,                  10'd0,    1, ST_FALSE, 64'h0, 11'd2},
    '{OP_ADD,   64'h2,                  10'd0,    1, ST_TRUE,  64'h0, 11'd3},
    '{3'd5,     64'h4,                  10'd0,    1, ST_FALSE, 64'h0, 11'd3},
    '{3'd6,     64'h4,                  10'd0,    1, ST_FALSE, 64'h0, 11'd3},
    '{3'd7,     64'hffff_ffff_ffff_ffff, 10'h3ff, 1, ST_FALSE, 64'h0, 11'd3},
    '{OP_CLEAR, 64'hffff_ffff_ffff_ffff, 10'h3ff, 1, ST_TRUE,  64'h0, 11'd0},
    '{OP_TEST,  64'hffff_ffff_ffff_fffe, 10'd0,   1, ST_FALSE, 64'h0, 11'd0}
  };

  // random phase on one table length
  task automatic run_phase(input int n);
    int burst;
    int r;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] k;
    logic [POS_W-1:0] pos;
    answer_t none;
    none = '{ST_TRUE, '0, '0};
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        go_idle();
        repeat ($urandom_range(0, 5)) @(negedge clk);
        burst = $urandom_range(1, 20);
      end
      burst--;
      r = $urandom_range(0, 99);
      pos = POS_W'($urandom_range(0, live_keys + 2));
      if ($urandom_range(0, 30) == 0) pos = POS_W'($urandom());
      if (r < 40) op = OP_ADD;
      else if (r < 55) op = OP_DEL;
      else if (r < 75) op = OP_TEST;
      else if (r < 88) op = OP_GET;
      else if (r < 90) op = OP_CLEAR;
      else if (r < 93) op = 3'($urandom_range(5, 7));
      else op = OP_TEST;
      if (known_keys.size() != 0 && $urandom_range(0, 1) && op != OP_ADD)
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else if (known_keys.size() != 0 && $urandom_range(0, 4) == 0)
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else k = fresh_key();
      if ($urandom_range(0, 40) == 0) k = $urandom_range(0, 1) ? '0 : ({$urandom(), $urandom()} | 64'h1);
      if (op == OP_ADD && k != '0 && !k[0]) known_keys.push_back(k);
      if (op == OP_CLEAR) known_keys.delete();
      send(op, k, pos, 1'b0, none);
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.operation = OP_ADD;
    in_bus.key = '0;
    in_bus.position = '0;
    len_log2 = LEN_LOG2_RST;
    wipe();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table at reset length
    foreach (rows[i])
      send(rows[i].op, rows[i].k, rows[i].pos, rows[i].pinned,
           '{rows[i].st, rows[i].el, rows[i].lc});
    drain();

    // smallest table fills quickly and reaches the full status
    stall_on = 1'b1;
    write_len(32'd2);
    run_phase(150);
    drain();
    write_len(32'd0);
    run_phase(100);
    drain();
    write_len(32'd4);
    run_phase(400);
    drain();
    write_len(32'd15);
    run_phase(300);
    drain();
    write_len(32'd6);
    stall_on = 1'b0;
    run_phase(300);
    drain();
    write_len(32'd10);
    stall_on = 1'b1;
    run_phase(600);
    drain();

    $display("covered %0d beats over lengths 2..10 plus out-of-range writes", sent);
    $display("adds refused as full: %0d, get ops: %0d", n_full, n_get);
    if (errors == 0 && answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
